### hw/rtl/ssp_pkg.sv
// Shared types and constants for the single-source shortest path block.
`timescale 1ns / 1ps
package ssp_pkg;

    localparam int VTX_W  = 6;
    localparam int CNT_W  = 7;
    localparam int DIST_W = 22;
    localparam int WIN_W  = 16;
    localparam logic [DIST_W-1:0] DIST_MAX = 22'h3FFFFF;

    localparam logic [CNT_W-1:0] VC_RESET = 7'd64;
    localparam logic [VTX_W-1:0] SV_RESET = 6'd0;

    localparam logic REG_VERTEX_COUNT = 1'b0;
    localparam logic REG_START_VERTEX = 1'b1;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_RUN  = 1'b1;

    typedef struct packed {
        logic [CNT_W-1:0] vcount;   // effective vertex count, 1..MAX
        logic [VTX_W-1:0] start;
    } t_cfg;

    typedef struct packed {
        logic             is_run;
        logic             in_range;
        logic [VTX_W-1:0] from;
        logic [VTX_W-1:0] to;
        logic [WIN_W-1:0] weight;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_q_head;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEL_RD,
        ST_SEL_CMP,
        ST_ED_RD,
        ST_ED_CHK,
        ST_ED_UPD,
        ST_EM_RD,
        ST_EM_OUT
    } t_state;

endpackage

### hw/rtl/ssp_in_if.sv
// Input channel: edge load and run words.
`timescale 1ns / 1ps
interface ssp_in_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [5:0]  edge_from;
    logic [5:0]  edge_to;
    logic [15:0] edge_weight;

    modport source (output valid, opcode, edge_from, edge_to, edge_weight, input ready);
    modport sink   (input valid, opcode, edge_from, edge_to, edge_weight, output ready);
endinterface

### hw/rtl/ssp_out_if.sv
// Output channel: one distance word per vertex.
`timescale 1ns / 1ps
interface ssp_out_if;
    logic        valid;
    logic        ready;
    logic [5:0]  vertex_index;
    logic        reachable;
    logic [21:0] path_distance;
    logic        last_vertex;
    logic        edges_dropped;
    logic        bad_start;

    modport source (output valid, vertex_index, reachable, path_distance, last_vertex,
                    edges_dropped, bad_start, input ready);
    modport sink   (input valid, vertex_index, reachable, path_distance, last_vertex,
                    edges_dropped, bad_start, output ready);
endinterface

### hw/rtl/ssp_cfg.sv
// APB register file: vertex count and start vertex.
`timescale 1ns / 1ps
module ssp_cfg
    import ssp_pkg::*;
#(
    parameter int MAX_VERTICES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready,
    output t_cfg        o_cfg
);
    localparam logic [CNT_W-1:0] VMAX = CNT_W'(MAX_VERTICES);

    logic [CNT_W-1:0] r_vc;
    logic [VTX_W-1:0] r_sv;
    logic             wr;

    assign o_pready = 1'b1;
    assign wr = i_psel && i_penable && i_pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vc <= VC_RESET;
            r_sv <= SV_RESET;
        end else if (wr) begin
            unique case (i_paddr[2])
                REG_VERTEX_COUNT: r_vc <= i_pwdata[CNT_W-1:0];
                REG_START_VERTEX: r_sv <= i_pwdata[VTX_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (i_paddr[2])
            REG_VERTEX_COUNT: o_prdata = {{(32-CNT_W){1'b0}}, r_vc};
            REG_START_VERTEX: o_prdata = {{(32-VTX_W){1'b0}}, r_sv};
            default:          o_prdata = '0;
        endcase
    end

    // zero counts as one, too large clamps to the maximum
    always_comb begin
        priority if (r_vc == '0)  o_cfg.vcount = CNT_W'(1);
        else if (r_vc > VMAX)     o_cfg.vcount = VMAX;
        else                      o_cfg.vcount = r_vc;
        o_cfg.start = r_sv;
    end
endmodule

### hw/rtl/ssp_front.sv
// Front end: accepts input words, checks endpoints, queues commands.
`timescale 1ns / 1ps
module ssp_front
    import ssp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    ssp_in_if.sink    i_in,
    input  t_cfg      i_cfg,
    input  logic      i_pop,
    output t_q_head   o_head
);
    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt, n_cnt;
    logic       push;
    t_cmd       cmd;

    assign i_in.ready = (r_cnt != 2'd2);
    assign push = i_in.valid && i_in.ready;

    always_comb begin
        cmd.is_run   = (i_in.opcode == OP_RUN);
        cmd.in_range = ({1'b0, i_in.edge_from} < i_cfg.vcount) &&
                       ({1'b0, i_in.edge_to} < i_cfg.vcount);
        cmd.from     = i_in.edge_from;
        cmd.to       = i_in.edge_to;
        cmd.weight   = i_in.edge_weight;
    end

    always_comb begin
        n_cnt = r_cnt;
        if (push && !i_pop)      n_cnt = r_cnt + 2'd1;
        else if (!push && i_pop) n_cnt = r_cnt - 2'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= cmd;
    end

    assign o_head.valid = (r_cnt != '0);
    assign o_head.cmd   = r_q[r_rp];

    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt <= 2'd2)
        else $error("queue overfilled");
    a_pop_ne: assert property (@(posedge i_clk) disable iff (!i_rst_n) i_pop |-> r_cnt != '0)
        else $error("pop from empty queue");
    a_both: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && i_pop) |=> $stable(r_cnt))
        else $error("queue count moved on push and pop");
endmodule

### hw/rtl/ssp_back.sv
// Back end: edge store, distance memory, nearest-vertex search and result emit.
`timescale 1ns / 1ps
module ssp_back
    import ssp_pkg::*;
#(
    parameter int MAX_VERTICES = 64,
    parameter int MAX_EDGES    = 1024,
    parameter int WEIGHT_BITS  = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  t_q_head   i_head,
    output logic      o_pop,
    ssp_out_if.source o_out
);
    localparam int VW   = $clog2(MAX_VERTICES);
    localparam int EAW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int ETW  = $clog2(MAX_EDGES + 1);
    localparam int WB_IN = (WEIGHT_BITS < WIN_W) ? WEIGHT_BITS : WIN_W;
    localparam int SW   = ((WEIGHT_BITS > DIST_W) ? WEIGHT_BITS : DIST_W) + 1;
    localparam int EW   = 2 * VTX_W + WEIGHT_BITS;
    localparam logic [ETW-1:0] EMAX = ETW'(MAX_EDGES);

    // memories
    logic [EW-1:0]     edge_mem [MAX_EDGES];
    logic [DIST_W-1:0] dist_mem [MAX_VERTICES];

    t_state r_state, n_state;
    logic [ETW-1:0]   r_etot, n_etot;
    logic             r_drop, n_drop;
    logic             r_bad, n_bad;
    logic [MAX_VERTICES-1:0] r_reached, n_reached, r_settled, n_settled;
    logic [CNT_W-1:0] r_vi, n_vi;
    logic             r_found, n_found;
    logic [VW-1:0]    r_bidx, n_bidx, r_u, n_u;
    logic [DIST_W-1:0] r_bd, n_bd, r_du, n_du;
    logic [ETW-1:0]   r_e, n_e;
    logic [VW-1:0]    r_t, n_t;
    logic [WEIGHT_BITS-1:0] r_w, n_w;

    // memory ports
    logic             e_we, e_re;
    logic [EW-1:0]    e_wd, r_eq;
    logic             d_we, d_re;
    logic [VW-1:0]    d_wa, d_ra;
    logic [DIST_W-1:0] d_wd, r_dq;

    // output register
    logic             r_ov, n_ov;
    logic             ld;
    logic [VTX_W-1:0] r_o_idx;
    logic             r_o_reach, r_o_last, r_o_drop, r_o_bad;
    logic [DIST_W-1:0] r_o_dist;
    logic             o_reach, o_last;

    logic [VTX_W-1:0] eq_f, eq_t;
    logic [WEIGHT_BITS-1:0] eq_w, in_w;
    logic [SW-1:0]    sum;
    logic [DIST_W-1:0] nd;
    logic             cand;
    logic [CNT_W-1:0] nm1;

    assign {eq_f, eq_t, eq_w} = r_eq;
    assign in_w = WEIGHT_BITS'(i_head.cmd.weight[WB_IN-1:0]);
    assign sum  = SW'(r_du) + SW'(r_w);
    assign nd   = (sum > SW'(DIST_MAX)) ? DIST_MAX : sum[DIST_W-1:0];
    assign nm1  = i_cfg.vcount - CNT_W'(1);
    assign cand = r_reached[r_vi[VW-1:0]] && !r_settled[r_vi[VW-1:0]] &&
                  (!r_found || r_dq < r_bd);
    assign o_reach = !r_bad && r_reached[r_vi[VW-1:0]];
    assign o_last  = (r_vi == nm1);

    always_comb begin
        logic f2;
        logic [VW-1:0] i2;
        logic [DIST_W-1:0] d2;
        n_state = r_state; n_etot = r_etot; n_drop = r_drop; n_bad = r_bad;
        n_reached = r_reached; n_settled = r_settled; n_vi = r_vi;
        n_found = r_found; n_bidx = r_bidx; n_bd = r_bd; n_u = r_u; n_du = r_du;
        n_e = r_e; n_t = r_t; n_w = r_w; n_ov = r_ov;
        o_pop = 1'b0; e_we = 1'b0; e_re = 1'b0; e_wd = {i_head.cmd.from, i_head.cmd.to, in_w};
        d_we = 1'b0; d_re = 1'b0; d_wa = '0; d_ra = r_vi[VW-1:0]; d_wd = '0;
        ld = 1'b0;
        f2 = r_found; i2 = r_bidx; d2 = r_bd;
        if (r_ov && o_out.ready) n_ov = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_head.valid) begin
                    o_pop = 1'b1;
                    if (!i_head.cmd.is_run) begin
                        if (i_head.cmd.in_range && r_etot < EMAX) begin
                            e_we   = 1'b1;
                            n_etot = r_etot + ETW'(1);
                        end else begin
                            n_drop = 1'b1;
                        end
                    end else begin
                        n_bad = ({1'b0, i_cfg.start} >= i_cfg.vcount);
                        n_vi  = '0;
                        n_found = 1'b0;
                        if ({1'b0, i_cfg.start} >= i_cfg.vcount) begin
                            n_state = ST_EM_RD;
                        end else begin
                            n_reached = '0;
                            n_reached[i_cfg.start[VW-1:0]] = 1'b1;
                            n_settled = '0;
                            d_we = 1'b1;
                            d_wa = i_cfg.start[VW-1:0];
                            d_wd = '0;
                            n_state = ST_SEL_RD;
                        end
                    end
                end
            end
            ST_SEL_RD: begin
                d_re = 1'b1;
                n_state = ST_SEL_CMP;
            end
            ST_SEL_CMP: begin
                if (cand) begin
                    f2 = 1'b1; i2 = r_vi[VW-1:0]; d2 = r_dq;
                end
                n_found = f2; n_bidx = i2; n_bd = d2;
                if (r_vi == nm1) begin
                    n_vi = '0;
                    if (f2) begin
                        n_settled[i2] = 1'b1;
                        n_u  = i2;
                        n_du = d2;
                        n_e  = '0;
                        n_found = 1'b0;
                        n_state = (r_etot == '0) ? ST_SEL_RD : ST_ED_RD;
                    end else begin
                        n_state = ST_EM_RD;
                    end
                end else begin
                    n_vi = r_vi + CNT_W'(1);
                    n_state = ST_SEL_RD;
                end
            end
            ST_ED_RD: begin
                e_re = 1'b1;
                n_state = ST_ED_CHK;
            end
            ST_ED_CHK: begin
                if ({1'b0, eq_f} == {{(CNT_W-VW){1'b0}}, r_u} &&
                    {1'b0, eq_t} < i_cfg.vcount) begin
                    d_re = 1'b1;
                    d_ra = eq_t[VW-1:0];
                    n_t  = eq_t[VW-1:0];
                    n_w  = eq_w;
                    n_state = ST_ED_UPD;
                end else if (r_e + ETW'(1) == r_etot) begin
                    n_state = ST_SEL_RD;
                end else begin
                    n_e = r_e + ETW'(1);
                    n_state = ST_ED_RD;
                end
            end
            ST_ED_UPD: begin
                if (!r_reached[r_t] || nd < r_dq) begin
                    d_we = 1'b1;
                    d_wa = r_t;
                    d_wd = nd;
                    n_reached[r_t] = 1'b1;
                end
                if (r_e + ETW'(1) == r_etot) begin
                    n_state = ST_SEL_RD;
                end else begin
                    n_e = r_e + ETW'(1);
                    n_state = ST_ED_RD;
                end
            end
            ST_EM_RD: begin
                d_re = 1'b1;
                n_state = ST_EM_OUT;
            end
            ST_EM_OUT: begin
                if (!r_ov || o_out.ready) begin
                    ld   = 1'b1;
                    n_ov = 1'b1;
                    if (o_last) begin
                        n_etot  = '0;
                        n_drop  = 1'b0;
                        n_state = ST_IDLE;
                    end else begin
                        n_vi    = r_vi + CNT_W'(1);
                        n_state = ST_EM_RD;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_etot    <= '0;
            r_drop    <= 1'b0;
            r_bad     <= 1'b0;
            r_reached <= '0;
            r_settled <= '0;
            r_vi      <= '0;
            r_found   <= 1'b0;
            r_e       <= '0;
            r_ov      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_etot    <= n_etot;
            r_drop    <= n_drop;
            r_bad     <= n_bad;
            r_reached <= n_reached;
            r_settled <= n_settled;
            r_vi      <= n_vi;
            r_found   <= n_found;
            r_e       <= n_e;
            r_ov      <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bidx <= n_bidx;
        r_bd   <= n_bd;
        r_u    <= n_u;
        r_du   <= n_du;
        r_t    <= n_t;
        r_w    <= n_w;
        if (ld) begin
            r_o_idx   <= r_vi[VTX_W-1:0];
            r_o_reach <= o_reach;
            r_o_dist  <= o_reach ? r_dq : '0;
            r_o_last  <= o_last;
            r_o_drop  <= r_drop;
            r_o_bad   <= r_bad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (e_we) edge_mem[r_etot[EAW-1:0]] <= e_wd;
        if (e_re) r_eq <= edge_mem[r_e[EAW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (d_we) dist_mem[d_wa] <= d_wd;
        if (d_re) r_dq <= dist_mem[d_ra];
    end

    assign o_out.valid         = r_ov;
    assign o_out.vertex_index  = r_o_idx;
    assign o_out.reachable     = r_o_reach;
    assign o_out.path_distance = r_o_dist;
    assign o_out.last_vertex   = r_o_last;
    assign o_out.edges_dropped = r_o_drop;
    assign o_out.bad_start     = r_o_bad;

    a_etot: assert property (@(posedge i_clk) disable iff (!i_rst_n) r_etot <= EMAX)
        else $error("edge count beyond store");
    a_settled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_settled & ~r_reached) == '0)
        else $error("settled vertex not reached");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> r_state == ST_IDLE)
        else $error("command taken while busy");
    a_ld_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ld |-> (!r_ov || o_out.ready))
        else $error("result overwritten");
endmodule

### hw/rtl/single_source_shortest_paths_top.sv
// Top level of the single-source shortest path block.
//
// Usage:
//   i_in : words with opcode 0 load one directed edge (from, to, weight) into
//          the edge store; opcode 1 runs the search from the start vertex.
//   o_out: a run emits one word per vertex 0..n-1, in order, last_vertex on
//          the final one. Loads emit nothing.
//   APB  : register 0 (addr 0) vertex_count, register 1 (addr 4) start_vertex.
//          Write only while the block is idle.
// Operation:
//   Loads stream one per cycle through the two-entry command queue while the
//   back end is idle. A run goes in rounds, one more than the number of
//   reached vertices: each round reads and compares the distance of every
//   vertex in turn to choose the nearest unsettled one, then reads every
//   stored edge in turn and reads and updates the distance at the end of
//   each edge leaving it; after the last round one word is emitted per vertex.
//   While a run is busy the queue fills and input ready drops.
// Reset: synchronous, active low; queue, edge count, drop flag and output
//   are cleared, registers return to 64 vertices and start vertex 0.
// Stall: a result waits in the output register while o_out.ready is low;
//   the emitter holds until it is taken, nothing is lost.
`timescale 1ns / 1ps
module single_source_shortest_paths_top
    import ssp_pkg::*;
#(
    parameter int MAX_VERTICES = 64,
    parameter int MAX_EDGES    = 1024,
    parameter int WEIGHT_BITS  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ssp_in_if.sink      i_in,
    ssp_out_if.source   o_out,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready
);
    t_cfg    cfg;
    t_q_head head;
    logic    pop;

    // register file, effective vertex count derived there
    ssp_cfg #(.MAX_VERTICES(MAX_VERTICES)) u_cfg (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_psel(i_psel), .i_penable(i_penable), .i_pwrite(i_pwrite),
        .i_paddr(i_paddr), .i_pwdata(i_pwdata),
        .o_prdata(o_prdata), .o_pready(o_pready), .o_cfg(cfg)
    );

    // accept and classify words, endpoint check against current count
    ssp_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in(i_in), .i_cfg(cfg), .i_pop(pop), .o_head(head)
    );

    // edge store, search engine and result emit
    ssp_back #(
        .MAX_VERTICES(MAX_VERTICES),
        .MAX_EDGES(MAX_EDGES),
        .WEIGHT_BITS(WEIGHT_BITS)
    ) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg(cfg), .i_head(head), .o_pop(pop), .o_out(o_out)
    );
endmodule

### tb/tb_single_source_shortest_paths_top.sv
// Testbench for the single-source shortest path block: directed, burst and random graphs.
`timescale 1ns / 1ps
module tb_single_source_shortest_paths_top;
    import ssp_pkg::*;

    localparam int MAX_V      = 64;
    localparam int MAX_E      = 1024;
    localparam int CYCLE_CAP  = 3000000;
    localparam int SETTLE_CYC = 40;     // loads may still sit in the command queue

    // A distance word as the block should emit it.
    typedef struct {
        logic [VTX_W-1:0]  vertex_index;
        logic              reachable;
        logic [DIST_W-1:0] path_distance;
        logic              last_vertex;
        logic              edges_dropped;
        logic              bad_start;
    } dist_word_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    ssp_in_if  in_ch();
    ssp_out_if out_ch();

    single_source_shortest_paths_top DUT (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (in_ch.sink),
        .o_out     (out_ch.source),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_pready  (pready)
    );

    always #1 i_clk = ~i_clk;

    // Shadow of the block: edge store, drop flag and the two registers.
    logic [VTX_W-1:0] store_from [MAX_E];
    logic [VTX_W-1:0] store_to   [MAX_E];
    logic [WIN_W-1:0] store_wt   [MAX_E];
    int               store_count;
    logic             drop_flag;
    logic [CNT_W-1:0] cfg_vcount;
    logic [VTX_W-1:0] cfg_start;

    dist_word_t pending_words[$];

    int  cycle_count;
    int  error_count;
    int  words_sent;
    int  runs_sent;
    int  words_checked;
    int  out_stall_left;

    initial begin
        in_ch.valid       = 1'b0;
        in_ch.opcode      = OP_LOAD;
        in_ch.edge_from   = '0;
        in_ch.edge_to     = '0;
        in_ch.edge_weight = '0;
        out_ch.ready      = 1'b0;
    end

    // Watchdog: fails the simulation once the total cycle count passes this cap.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("timeout at %0t after %0d cycles", $time, cycle_count);
            $display("single_source_shortest_paths_top test failed");
            $finish;
        end
    end

    // Output back-pressure: mostly ready, short random drops, now and then a long stall.
    always @(negedge i_clk) begin
        if (out_stall_left > 0) begin
            out_stall_left = out_stall_left - 1;
            out_ch.ready = 1'b0;
        end else if ($urandom_range(0, 99) < 2) begin
            out_stall_left = $urandom_range(20, 80);
            out_ch.ready = 1'b0;
        end else begin
            out_ch.ready = ($urandom_range(0, 9) < 7);
        end
    end

    // Result checker: every accepted word against the oldest expectation.
    always @(posedge i_clk) begin
        dist_word_t exp_w;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            words_checked = words_checked + 1;
            if (pending_words.size() == 0) begin
                $display("%0t: unexpected word vertex=%0d dist=%0d", $time,
                         out_ch.vertex_index, out_ch.path_distance);
                error_count = error_count + 1;
            end else begin
                exp_w = pending_words.pop_front();
                if (out_ch.vertex_index !== exp_w.vertex_index ||
                    out_ch.reachable !== exp_w.reachable ||
                    out_ch.path_distance !== exp_w.path_distance ||
                    out_ch.last_vertex !== exp_w.last_vertex ||
                    out_ch.edges_dropped !== exp_w.edges_dropped ||
                    out_ch.bad_start !== exp_w.bad_start) begin
                    $display("%0t: mismatch exp v=%0d r=%0d d=%0d l=%0d dr=%0d b=%0d",
                             $time, exp_w.vertex_index, exp_w.reachable,
                             exp_w.path_distance, exp_w.last_vertex,
                             exp_w.edges_dropped, exp_w.bad_start);
                    $display("%0t:          got v=%0d r=%0d d=%0d l=%0d dr=%0d b=%0d",
                             $time, out_ch.vertex_index, out_ch.reachable,
                             out_ch.path_distance, out_ch.last_vertex,
                             out_ch.edges_dropped, out_ch.bad_start);
                    error_count = error_count + 1;
                end
            end
        end
    end

    function automatic int eff_count();
        if (cfg_vcount == 0)
            return 1;
        if (cfg_vcount > MAX_V)
            return MAX_V;
        return int'(cfg_vcount);
    endfunction

    // Load: store the edge or flag a drop (store full / endpoint out of range).
    task automatic shadow_load(logic [VTX_W-1:0] f, logic [VTX_W-1:0] t,
                               logic [WIN_W-1:0] w);
        int n;
        n = eff_count();
        if (store_count >= MAX_E || f >= n || t >= n) begin
            drop_flag = 1'b1;
        end else begin
            store_from[store_count] = f;
            store_to[store_count]   = t;
            store_wt[store_count]   = w;
            store_count = store_count + 1;
        end
    endtask

    // Run: nearest-first search over the shadow store, queue one word per vertex.
    task automatic shadow_search();
        int n, u, i, e;
        logic bad;
        logic [DIST_W-1:0] best_d [MAX_V];
        logic reached [MAX_V];
        logic settled [MAX_V];
        logic [DIST_W:0] sum;
        dist_word_t w;
        n = eff_count();
        bad = (cfg_start >= n);
        for (i = 0; i < MAX_V; i++) begin
            best_d[i] = '0;
            reached[i] = 1'b0;
            settled[i] = 1'b0;
        end
        if (!bad) begin
            reached[cfg_start] = 1'b1;
            forever begin
                u = n;
                for (i = 0; i < n; i++)
                    if (reached[i] && !settled[i] && (u == n || best_d[i] < best_d[u]))
                        u = i;
                if (u == n)
                    break;
                settled[u] = 1'b1;
                for (e = 0; e < store_count; e++) begin
                    if (store_from[e] != u || store_to[e] >= n)
                        continue;
                    sum = {1'b0, best_d[u]} + store_wt[e];
                    if (sum > DIST_MAX)
                        sum = {1'b0, DIST_MAX};
                    if (!reached[store_to[e]] || sum[DIST_W-1:0] < best_d[store_to[e]]) begin
                        reached[store_to[e]] = 1'b1;
                        best_d[store_to[e]] = sum[DIST_W-1:0];
                    end
                end
            end
        end
        for (i = 0; i < n; i++) begin
            w.vertex_index  = i[VTX_W-1:0];
            w.reachable     = !bad && reached[i];
            w.path_distance = w.reachable ? best_d[i] : '0;
            w.last_vertex   = (i == n - 1);
            w.edges_dropped = drop_flag;
            w.bad_start     = bad;
            pending_words.insert(pending_words.size(), w);
        end
        store_count = 0;
        drop_flag = 1'b0;
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Send one word; valid stays high into the next word when no gap follows.
    task automatic send_word(logic op, int f, int t, int w, bit no_gap = 0);
        int gap;
        @(negedge i_clk);
        in_ch.valid       = 1'b1;
        in_ch.opcode      = op;
        in_ch.edge_from   = VTX_W'(f);
        in_ch.edge_to     = VTX_W'(t);
        in_ch.edge_weight = WIN_W'(w);
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
        words_sent = words_sent + 1;
        if (op == OP_RUN) begin
            runs_sent = runs_sent + 1;
            shadow_search();
        end else begin
            shadow_load(VTX_W'(f), VTX_W'(t), WIN_W'(w));
        end
        gap = no_gap ? 0 : pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            in_ch.valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // Wait for every expected word, then let queued loads finish.
    task automatic drain();
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (pending_words.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYC) @(negedge i_clk);
    endtask

    // APB write followed by a read-back of the same register.
    task automatic reg_write(logic idx, logic [31:0] val);
        logic [31:0] want;
        paddr  = {idx, 2'b00};
        pwdata = val;
        pwrite = 1'b1;
        psel   = 1'b1;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        @(negedge i_clk);
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        if (idx == REG_VERTEX_COUNT) begin
            cfg_vcount = val[CNT_W-1:0];
            want = {25'b0, cfg_vcount};
        end else begin
            cfg_start = val[VTX_W-1:0];
            want = {26'b0, cfg_start};
        end
        if (prdata !== want) begin
            $display("%0t: register %0d readback exp %0h got %0h", $time, idx, want, prdata);
            error_count = error_count + 1;
        end
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic set_graph(int vc, int st);
        drain();
        reg_write(REG_VERTEX_COUNT, vc);
        reg_write(REG_START_VERTEX, st);
    endtask

    // Directed: extremes, drops, lowered count, bad start, count 0 and 127.
    task automatic test_directed();
        int i;
        // reset settings: 64 vertices, start 0; long max-weight chain to vertex 63
        for (i = 0; i < 8; i++)
            send_word(OP_LOAD, i * 9, (i == 7) ? 63 : (i + 1) * 9, 16'hFFFF);
        send_word(OP_LOAD, 0, 63, 16'h0000);
        send_word(OP_LOAD, 63, 0, 16'hAAAA);
        send_word(OP_RUN, 6'h2A, 6'h15, 16'h5555);
        // endpoint out of range at load time
        set_graph(8, 2);
        send_word(OP_LOAD, 2, 10, 16'd5);
        send_word(OP_LOAD, 40, 3, 16'd5);
        send_word(OP_LOAD, 2, 3, 16'd7);
        send_word(OP_LOAD, 3, 7, 16'd1);
        send_word(OP_RUN, 0, 0, 0);
        // count lowered after loading: stored edges above it are ignored silently
        set_graph(16, 0);
        send_word(OP_LOAD, 0, 12, 16'd1);
        send_word(OP_LOAD, 0, 3, 16'd9);
        send_word(OP_LOAD, 12, 1, 16'd1);
        set_graph(4, 0);
        send_word(OP_RUN, 0, 0, 0);
        // bad start: nothing reachable, store still emptied
        set_graph(4, 5);
        send_word(OP_LOAD, 0, 1, 16'd3);
        send_word(OP_RUN, 0, 0, 0);
        // count 0 acts as 1, count 127 acts as 64
        set_graph(0, 0);
        send_word(OP_LOAD, 0, 0, 16'd4);
        send_word(OP_RUN, 0, 0, 0);
        set_graph(127, 63);
        send_word(OP_LOAD, 63, 1, 16'd2);
        send_word(OP_RUN, 0, 0, 0);
    endtask

    // Back-to-back loads and runs with no gaps, sender held until results return.
    task automatic test_burst();
        int i;
        set_graph(12, 0);
        for (i = 0; i < 12; i++)
            send_word(OP_LOAD, $urandom_range(0, 11), $urandom_range(0, 11),
                      $urandom_range(0, 65535), 1);
        send_word(OP_RUN, 0, 0, 0, 1);
        // hold off until every word has come back
        drain();
        for (i = 0; i < 11; i++)
            send_word(OP_LOAD, $urandom_range(0, 11), $urandom_range(0, 11),
                      $urandom_range(0, 300), 1);
        send_word(OP_RUN, 0, 0, 0, 1);
    endtask

    // Random graphs, mostly small and well formed, some noise and full-width fields.
    task automatic test_random(int word_budget);
        int start_words, vc, n, st, ne, i, f, t;
        bit wide;
        start_words = words_sent;
        while (words_sent - start_words < word_budget) begin
            wide = ($urandom_range(0, 4) == 0);
            vc = wide ? $urandom_range(48, 127) : $urandom_range(1, 16);
            n  = (vc > MAX_V) ? MAX_V : vc;
            st = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, n - 1);
            set_graph(vc, st);
            ne = $urandom_range(0, 25);
            for (i = 0; i < ne; i++) begin
                if ($urandom_range(0, 9) == 0) begin
                    f = $urandom_range(0, 63);
                    t = $urandom_range(0, 63);
                end else begin
                    f = (i < n && $urandom_range(0, 1)) ? (st + i) % n : $urandom_range(0, n - 1);
                    t = $urandom_range(0, n - 1);
                end
                send_word(OP_LOAD, f, t,
                          $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535)
                                                    : $urandom_range(0, 300));
            end
            send_word(OP_RUN, $urandom_range(0, 63), $urandom_range(0, 63),
                      $urandom_range(0, 65535));
        end
    endtask

    initial begin
        cycle_count = 0;
        error_count = 0;
        words_sent = 0;
        runs_sent = 0;
        words_checked = 0;
        out_stall_left = 0;
        store_count = 0;
        drop_flag = 1'b0;
        cfg_vcount = VC_RESET;
        cfg_start = SV_RESET;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_burst();
        test_random(410);
        drain();
        repeat (100) @(negedge i_clk);
        $display("covered %0d input words, %0d searches, %0d distance words checked",
                 words_sent, runs_sent, words_checked);
        if (error_count == 0 && pending_words.size() == 0) begin
            $display("single_source_shortest_paths_top test passed");
        end else begin
            $display("single_source_shortest_paths_top test failed");
        end
        $finish;
    end

endmodule
